// ===== hdl/sfeb_pkg.sv =====
// ----------------------------------------------------------------------------
// sfeb_pkg
// Shared types, constants and helpers of the stereo FIR equalizer.
// ----------------------------------------------------------------------------
package sfeb_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int LEVEL_W    = 10;
   localparam int COEF_IDX_W = 6;
   localparam int PROD_W     = 2 * SAMPLE_W;
   localparam int CSR_IDX_W  = 1;
   localparam int ROUND_BIAS = 1 << (SAMPLE_W - 2);

   localparam logic signed [LEVEL_W:0]    LEVEL_WINDOW = 11'sd12;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX   = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN   = 16'sh8000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BYPASS_LEVEL   = 1'b0,
      CSR_EQUALIZE_LEVEL = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_AUDIO = 1'b0,
      KIND_COEF  = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic clear;
      logic hist_we;
      logic coef_we;
      logic rd_en;
      logic acc_clear;
      logic finish;
   } seq_ctrl_type;

   function automatic logic near_level(input logic [LEVEL_W-1:0] reading,
                                       input logic [LEVEL_W-1:0] level);
      logic signed [LEVEL_W:0] diff;
      diff = $signed({1'b0, reading}) - $signed({1'b0, level});
      near_level = (diff < LEVEL_WINDOW) && (diff > -LEVEL_WINDOW);
   endfunction

endpackage

// ===== hdl/sfeb_store.sv =====
// ----------------------------------------------------------------------------
// sfeb_store
// Coefficient table and left/right delay lines, one write and one
// registered read port each.
// ----------------------------------------------------------------------------
module sfeb_store #(
   parameter int TAP_COUNT = 64,
   parameter int AW        = 6
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  sfeb_pkg::seq_ctrl_type                  ctrl,
   input  logic [AW-1:0]                           hist_wr_addr,
   input  logic [AW-1:0]                           coef_wr_addr,
   input  logic [AW-1:0]                           hist_rd_addr,
   input  logic [AW-1:0]                           coef_rd_addr,
   input  logic signed [sfeb_pkg::SAMPLE_W-1:0]    left_wr,
   input  logic signed [sfeb_pkg::SAMPLE_W-1:0]    right_wr,
   input  logic signed [sfeb_pkg::SAMPLE_W-1:0]    coef_wr,
   output logic signed [sfeb_pkg::SAMPLE_W-1:0]    left_rd,
   output logic signed [sfeb_pkg::SAMPLE_W-1:0]    right_rd,
   output logic signed [sfeb_pkg::SAMPLE_W-1:0]    coef_rd,
   output logic                                    rd_vld
);
   import sfeb_pkg::*;

   logic signed [SAMPLE_W-1:0] coef_mem  [TAP_COUNT];
   logic signed [SAMPLE_W-1:0] left_mem  [TAP_COUNT];
   logic signed [SAMPLE_W-1:0] right_mem [TAP_COUNT];

   logic signed [SAMPLE_W-1:0] coef_rd_ff;
   logic signed [SAMPLE_W-1:0] left_rd_ff;
   logic signed [SAMPLE_W-1:0] right_rd_ff;
   logic                       rd_vld_ff;

   logic signed [SAMPLE_W-1:0] coef_wr_in;
   logic signed [SAMPLE_W-1:0] left_wr_in;
   logic signed [SAMPLE_W-1:0] right_wr_in;

   assign coef_wr_in  = ctrl.clear ? '0 : coef_wr;
   assign left_wr_in  = ctrl.clear ? '0 : left_wr;
   assign right_wr_in = ctrl.clear ? '0 : right_wr;

   always_ff @(posedge clock) begin
      if (ctrl.coef_we) begin
         coef_mem[coef_wr_addr] <= coef_wr_in;
      end
      if (ctrl.rd_en) begin
         coef_rd_ff <= coef_mem[coef_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.hist_we) begin
         left_mem[hist_wr_addr]  <= left_wr_in;
         right_mem[hist_wr_addr] <= right_wr_in;
      end
      if (ctrl.rd_en) begin
         left_rd_ff  <= left_mem[hist_rd_addr];
         right_rd_ff <= right_mem[hist_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= ctrl.rd_en;
      end
   end

   assign coef_rd  = coef_rd_ff;
   assign left_rd  = left_rd_ff;
   assign right_rd = right_rd_ff;
   assign rd_vld   = rd_vld_ff;

endmodule

// ===== hdl/sfeb_mac.sv =====
// ----------------------------------------------------------------------------
// sfeb_mac
// Two-lane multiply-accumulate unit, reused once per tap, with Q15
// rounding and saturation of the final sums.
// ----------------------------------------------------------------------------
module sfeb_mac #(
   parameter int AW = 6
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    acc_clear,
   input  logic                                    rd_vld,
   input  logic signed [sfeb_pkg::SAMPLE_W-1:0]    coef_rd,
   input  logic signed [sfeb_pkg::SAMPLE_W-1:0]    left_rd,
   input  logic signed [sfeb_pkg::SAMPLE_W-1:0]    right_rd,
   output logic signed [sfeb_pkg::SAMPLE_W-1:0]    left_fir,
   output logic signed [sfeb_pkg::SAMPLE_W-1:0]    right_fir
);
   import sfeb_pkg::*;

   localparam int ACC_W = PROD_W + 1 + AW;

   logic signed [PROD_W-1:0] prod_l_ff;
   logic signed [PROD_W-1:0] prod_r_ff;
   logic                     prod_vld_ff;
   logic signed [ACC_W-1:0]  acc_l_ff;
   logic signed [ACC_W-1:0]  acc_r_ff;
   logic signed [ACC_W-1:0]  acc_l_in;
   logic signed [ACC_W-1:0]  acc_r_in;

   function automatic logic signed [SAMPLE_W-1:0] round_sat(
      input logic signed [ACC_W-1:0] acc
   );
      logic signed [ACC_W-1:0]        sum;
      logic [ACC_W-PROD_W+1:0]        hi;
      sum = acc + $signed(ACC_W'(ROUND_BIAS));
      hi  = sum[ACC_W-1:PROD_W-2];
      if ((&hi) || !(|hi)) begin
         round_sat = sum[PROD_W-2:SAMPLE_W-1];
      end else if (sum[ACC_W-1]) begin
         round_sat = SAMPLE_MIN;
      end else begin
         round_sat = SAMPLE_MAX;
      end
   endfunction

   always_ff @(posedge clock) begin
      prod_l_ff <= coef_rd * left_rd;
      prod_r_ff <= coef_rd * right_rd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= rd_vld;
      end
   end

   always_comb begin
      acc_l_in = acc_l_ff;
      acc_r_in = acc_r_ff;
      if (acc_clear) begin
         acc_l_in = '0;
         acc_r_in = '0;
      end else if (prod_vld_ff) begin
         acc_l_in = acc_l_ff + {{(ACC_W-PROD_W){prod_l_ff[PROD_W-1]}}, prod_l_ff};
         acc_r_in = acc_r_ff + {{(ACC_W-PROD_W){prod_r_ff[PROD_W-1]}}, prod_r_ff};
      end
   end

   always_ff @(posedge clock) begin
      acc_l_ff <= acc_l_in;
      acc_r_ff <= acc_r_in;
   end

   assign left_fir  = round_sat(acc_l_ff);
   assign right_fir = round_sat(acc_r_ff);

endmodule

// ===== hdl/sfeb_seq.sv =====
// ----------------------------------------------------------------------------
// sfeb_seq
// Sequencer: clearing pass, request intake, tap loop, pipeline drain and
// result hand-off.
// ----------------------------------------------------------------------------
module sfeb_seq #(
   parameter int TAP_COUNT = 64,
   parameter int AW        = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_kind,
   input  logic [sfeb_pkg::COEF_IDX_W-1:0]     req_coef_index,
   output logic                                req_ready,
   input  logic                                rsp_free,
   output sfeb_pkg::seq_ctrl_type              ctrl,
   output logic [AW-1:0]                       hist_wr_addr,
   output logic [AW-1:0]                       coef_wr_addr,
   output logic [AW-1:0]                       hist_rd_addr,
   output logic [AW-1:0]                       coef_rd_addr
);
   import sfeb_pkg::*;

   localparam logic [AW-1:0] LAST_TAP   = AW'(TAP_COUNT - 1);
   localparam logic [AW-1:0] DRAIN_LAST = AW'(1);

   seq_state_type state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0] head_prev;
   logic [AW-1:0] rd_ptr_next;
   logic          idx_ok;

   assign head_prev   = (head_ff == '0) ? LAST_TAP : head_ff - 1'b1;
   assign rd_ptr_next = (rd_ptr_ff == LAST_TAP) ? '0 : rd_ptr_ff + 1'b1;
   assign idx_ok      = 32'(req_coef_index) < TAP_COUNT;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         cnt_ff    <= '0;
         head_ff   <= '0;
         rd_ptr_ff <= '0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         head_ff   <= head_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      head_in      = head_ff;
      rd_ptr_in    = rd_ptr_ff;
      ctrl         = '0;
      req_ready    = 1'b0;
      hist_wr_addr = head_prev;
      coef_wr_addr = AW'(req_coef_index);
      hist_rd_addr = rd_ptr_ff;
      coef_rd_addr = cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            ctrl.clear   = 1'b1;
            ctrl.hist_we = 1'b1;
            ctrl.coef_we = 1'b1;
            hist_wr_addr = cnt_ff;
            coef_wr_addr = cnt_ff;
            if (cnt_ff == LAST_TAP) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               if (req_kind == KIND_COEF) begin
                  ctrl.coef_we = idx_ok;
               end else begin
                  ctrl.hist_we   = 1'b1;
                  ctrl.acc_clear = 1'b1;
                  head_in        = head_prev;
                  rd_ptr_in      = head_prev;
                  cnt_in         = '0;
                  state_in       = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            ctrl.rd_en = 1'b1;
            rd_ptr_in  = rd_ptr_next;
            if (cnt_ff == LAST_TAP) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (cnt_ff == DRAIN_LAST) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               ctrl.finish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/stereo_fir_equalizer_bypass.sv =====
// ----------------------------------------------------------------------------
// stereo_fir_equalizer_bypass
// Audio request: the single two-lane MAC walks every tap, and no new request
// is taken until the result has been handed off.
// Coefficient write: taken in the idle state, no result.
// Reset: synchronous; a clearing pass over all TAP_COUNT entries zeroes the
// coefficient table and delay lines before the first request is taken.
// ----------------------------------------------------------------------------
module stereo_fir_equalizer_bypass #(
   parameter int TAP_COUNT = 64
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_kind,
   input  logic signed [sfeb_pkg::SAMPLE_W-1:0]    req_left_sample,
   input  logic signed [sfeb_pkg::SAMPLE_W-1:0]    req_right_sample,
   input  logic [sfeb_pkg::LEVEL_W-1:0]            req_button_level,
   input  logic [sfeb_pkg::COEF_IDX_W-1:0]         req_coef_index,
   input  logic signed [sfeb_pkg::SAMPLE_W-1:0]    req_coef_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [sfeb_pkg::SAMPLE_W-1:0]    rsp_left_out,
   output logic signed [sfeb_pkg::SAMPLE_W-1:0]    rsp_right_out,
   output logic                                    rsp_eq_active,
   input  logic                                    csr_we,
   input  logic [sfeb_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [sfeb_pkg::LEVEL_W-1:0]            csr_wdata
);
   import sfeb_pkg::*;

   localparam int AW = $clog2(TAP_COUNT);

   logic [LEVEL_W-1:0]         bypass_level_ff;
   logic [LEVEL_W-1:0]         equalize_level_ff;
   logic                       mode_ff, mode_in;
   logic signed [SAMPLE_W-1:0] raw_l_ff;
   logic signed [SAMPLE_W-1:0] raw_r_ff;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_left_out_ff;
   logic signed [SAMPLE_W-1:0] rsp_right_out_ff;
   logic                       rsp_eq_active_ff;

   seq_ctrl_type               ctrl;
   logic [AW-1:0]              hist_wr_addr;
   logic [AW-1:0]              coef_wr_addr;
   logic [AW-1:0]              hist_rd_addr;
   logic [AW-1:0]              coef_rd_addr;
   logic signed [SAMPLE_W-1:0] left_rd;
   logic signed [SAMPLE_W-1:0] right_rd;
   logic signed [SAMPLE_W-1:0] coef_rd;
   logic                       rd_vld;
   logic signed [SAMPLE_W-1:0] left_fir;
   logic signed [SAMPLE_W-1:0] right_fir;
   logic                       rsp_free;
   logic                       audio_accept;

   assign rsp_free     = !rsp_valid_ff || rsp_ready;
   assign audio_accept = req_valid && req_ready && (req_kind == KIND_AUDIO);

   sfeb_seq #(
      .TAP_COUNT (TAP_COUNT),
      .AW        (AW)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_kind       (req_kind),
      .req_coef_index (req_coef_index),
      .req_ready      (req_ready),
      .rsp_free       (rsp_free),
      .ctrl           (ctrl),
      .hist_wr_addr   (hist_wr_addr),
      .coef_wr_addr   (coef_wr_addr),
      .hist_rd_addr   (hist_rd_addr),
      .coef_rd_addr   (coef_rd_addr)
   );

   sfeb_store #(
      .TAP_COUNT (TAP_COUNT),
      .AW        (AW)
   ) u_store (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .hist_wr_addr (hist_wr_addr),
      .coef_wr_addr (coef_wr_addr),
      .hist_rd_addr (hist_rd_addr),
      .coef_rd_addr (coef_rd_addr),
      .left_wr      (req_left_sample),
      .right_wr     (req_right_sample),
      .coef_wr      (req_coef_value),
      .left_rd      (left_rd),
      .right_rd     (right_rd),
      .coef_rd      (coef_rd),
      .rd_vld       (rd_vld)
   );

   sfeb_mac #(
      .AW (AW)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .acc_clear (ctrl.acc_clear),
      .rd_vld    (rd_vld),
      .coef_rd   (coef_rd),
      .left_rd   (left_rd),
      .right_rd  (right_rd),
      .left_fir  (left_fir),
      .right_fir (right_fir)
   );

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_level_ff   <= '0;
         equalize_level_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BYPASS_LEVEL:   bypass_level_ff   <= csr_wdata;
            CSR_EQUALIZE_LEVEL: equalize_level_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      mode_in = mode_ff;
      if (near_level(req_button_level, bypass_level_ff)) begin
         mode_in = 1'b0;
      end else if (near_level(req_button_level, equalize_level_ff)) begin
         mode_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (audio_accept) begin
         mode_ff <= mode_in;
      end
   end

   // hold raw pair for bypass
   always_ff @(posedge clock) begin
      if (audio_accept) begin
         raw_l_ff <= req_left_sample;
         raw_r_ff <= req_right_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         rsp_left_out_ff  <= mode_ff ? left_fir  : raw_l_ff;
         rsp_right_out_ff <= mode_ff ? right_fir : raw_r_ff;
         rsp_eq_active_ff <= mode_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_out_ff;
   assign rsp_right_out = rsp_right_out_ff;
   assign rsp_eq_active = rsp_eq_active_ff;

   a_busy_after_audio: assert property (@(posedge clock) disable iff (reset)
      (!reset && audio_accept) |=> !req_ready)
      else $error("request taken while an audio request is in progress");

   a_finish_no_intake: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |-> !(req_valid && req_ready))
      else $error("request taken in the result hand-off cycle");

   a_mode_holds: assert property (@(posedge clock) disable iff (reset)
      (!reset && !audio_accept) |=> $stable(mode_ff))
      else $error("mode changed without an audio request");

endmodule

// ===== test/stereo_fir_equalizer_bypass_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_fir_equalizer_bypass_checker
// Watches the request, result and register ports of the stereo FIR
// equalizer. It keeps its own copy of the mode, both delay lines and the
// coefficient table. It works out the sample pair and mode flag that each
// audio request must return, and compares every result against the oldest
// pending one.
// ----------------------------------------------------------------------------
module stereo_fir_equalizer_bypass_checker #(
   parameter int TAP_COUNT = 64
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_ready,
   input  logic                                    req_kind,
   input  logic signed [sfeb_pkg::SAMPLE_W-1:0]    req_left_sample,
   input  logic signed [sfeb_pkg::SAMPLE_W-1:0]    req_right_sample,
   input  logic [sfeb_pkg::LEVEL_W-1:0]            req_button_level,
   input  logic [sfeb_pkg::COEF_IDX_W-1:0]         req_coef_index,
   input  logic signed [sfeb_pkg::SAMPLE_W-1:0]    req_coef_value,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   input  logic signed [sfeb_pkg::SAMPLE_W-1:0]    rsp_left_out,
   input  logic signed [sfeb_pkg::SAMPLE_W-1:0]    rsp_right_out,
   input  logic                                    rsp_eq_active,
   input  logic                                    csr_we,
   input  logic [sfeb_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [sfeb_pkg::LEVEL_W-1:0]            csr_wdata,
   output int                                      mismatches,
   output int                                      awaiting_count
);

   import sfeb_pkg::*;

   localparam int     BUTTON_WINDOW = 12;
   localparam longint ROUND_HALF    = 64'sd16384;
   localparam longint SAT_BOUND     = 64'sd1073741824;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
      logic                       eq_active;
   } stereo_result_type;

   logic [LEVEL_W-1:0]         bypass_level;
   logic [LEVEL_W-1:0]         equalize_level;
   logic                       equalize_on;
   logic signed [SAMPLE_W-1:0] history [2][TAP_COUNT];
   logic signed [SAMPLE_W-1:0] coef_table [TAP_COUNT];
   stereo_result_type          awaiting_results [$];

   function automatic logic within_window(input logic [LEVEL_W-1:0] reading,
                                          input logic [LEVEL_W-1:0] centre);
      int r;
      int c;
      r = reading;
      c = centre;
      return (r < c + BUTTON_WINDOW) && (r > c - BUTTON_WINDOW);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] filter_channel(
      input int ch, input logic signed [SAMPLE_W-1:0] sample);
      longint acc;
      longint shifted;
      acc = 0;
      for (int k = TAP_COUNT - 1; k > 0; k--) history[ch][k] = history[ch][k-1];
      history[ch][0] = sample;
      for (int k = 0; k < TAP_COUNT; k++)
         acc += longint'(coef_table[k]) * longint'(history[ch][k]);
      acc += ROUND_HALF;
      if (acc >= SAT_BOUND) return SAMPLE_MAX;
      if (acc < -SAT_BOUND) return SAMPLE_MIN;
      shifted = acc >>> 15;
      return shifted[SAMPLE_W-1:0];
   endfunction

   function automatic stereo_result_type equalize_request();
      stereo_result_type res;
      logic signed [SAMPLE_W-1:0] left_y;
      logic signed [SAMPLE_W-1:0] right_y;
      if (within_window(req_button_level, bypass_level)) equalize_on = 1'b0;
      else if (within_window(req_button_level, equalize_level)) equalize_on = 1'b1;
      left_y  = filter_channel(0, req_left_sample);
      right_y = filter_channel(1, req_right_sample);
      res.left_out  = equalize_on ? left_y : req_left_sample;
      res.right_out = equalize_on ? right_y : req_right_sample;
      res.eq_active = equalize_on;
      return res;
   endfunction

   always @(posedge clock) begin
      stereo_result_type want;
      if (reset) begin
         bypass_level   = '0;
         equalize_level = '0;
         equalize_on    = 1'b0;
         for (int k = 0; k < TAP_COUNT; k++) begin
            history[0][k] = '0;
            history[1][k] = '0;
            coef_table[k] = '0;
         end
         awaiting_results.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaiting_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result left %0d right %0d eq %0b",
                        $time, rsp_left_out, rsp_right_out, rsp_eq_active);
            end else begin
               want = awaiting_results.pop_front();
               if (rsp_left_out !== want.left_out) begin
                  mismatches++;
                  $display("%0t: left_out expected %0d actual %0d",
                           $time, want.left_out, rsp_left_out);
               end
               if (rsp_right_out !== want.right_out) begin
                  mismatches++;
                  $display("%0t: right_out expected %0d actual %0d",
                           $time, want.right_out, rsp_right_out);
               end
               if (rsp_eq_active !== want.eq_active) begin
                  mismatches++;
                  $display("%0t: eq_active expected %0b actual %0b",
                           $time, want.eq_active, rsp_eq_active);
               end
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_BYPASS_LEVEL) bypass_level = csr_wdata;
            else if (csr_index == CSR_EQUALIZE_LEVEL) equalize_level = csr_wdata;
         end
         if (req_valid && req_ready) begin
            if (req_kind == KIND_COEF) begin
               if (int'(req_coef_index) < TAP_COUNT) coef_table[req_coef_index] = req_coef_value;
            end else begin
               awaiting_results.push_back(equalize_request());
            end
         end
      end
      awaiting_count = awaiting_results.size();
   end

endmodule

// ===== test/stereo_fir_equalizer_bypass_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_fir_equalizer_bypass_test
// Drives the stereo FIR equalizer with directed requests (sample extremes,
// saturation, level window edges, overlapping levels, levels at zero and
// full scale) and then with phases of random coefficient writes and audio
// requests, under random request gaps and result stalls. Checking is done
// by the checker instance; this module gives the verdict.
// ----------------------------------------------------------------------------
module stereo_fir_equalizer_bypass_test;

   import sfeb_pkg::*;

   localparam int TAP_COUNT    = 64;
   localparam int QUIET_LIMIT  = 4000;
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_ITEMS  = 200;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic                        req_kind;
   logic signed [SAMPLE_W-1:0]  req_left_sample;
   logic signed [SAMPLE_W-1:0]  req_right_sample;
   logic [LEVEL_W-1:0]          req_button_level;
   logic [COEF_IDX_W-1:0]       req_coef_index;
   logic signed [SAMPLE_W-1:0]  req_coef_value;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic signed [SAMPLE_W-1:0]  rsp_left_out;
   logic signed [SAMPLE_W-1:0]  rsp_right_out;
   logic                        rsp_eq_active;
   logic                        csr_we;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [LEVEL_W-1:0]          csr_wdata;
   int                          mismatches;
   int                          awaiting_count;
   bit                          req_gaps_on;
   bit                          rsp_stalls_on;
   int                          bypass_setting;
   int                          equalize_setting;

   stereo_fir_equalizer_bypass #(.TAP_COUNT(TAP_COUNT)) DUT (.*);

   stereo_fir_equalizer_bypass_checker #(.TAP_COUNT(TAP_COUNT)) CHECK (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int idle_span(input bit enabled);
      int roll;
      if (!enabled) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 4);
      return $urandom_range(20, 200);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return SAMPLE_MAX;
      if (roll == 1) return SAMPLE_MIN;
      return 16'($urandom);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_coef();
      if ($urandom_range(0, 9) < 7) return 16'($urandom_range(0, 4095) - 2048);
      return 16'($urandom);
   endfunction

   task automatic send_request(input kind_type kind,
                               input logic signed [SAMPLE_W-1:0] left_s,
                               input logic signed [SAMPLE_W-1:0] right_s,
                               input logic [LEVEL_W-1:0] reading,
                               input logic [COEF_IDX_W-1:0] tap,
                               input logic signed [SAMPLE_W-1:0] value);
      int gap;
      gap = idle_span(req_gaps_on);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_kind         = kind;
      req_left_sample  = left_s;
      req_right_sample = right_s;
      req_button_level = reading;
      req_coef_index   = tap;
      req_coef_value   = value;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_audio(input int left_s, input int right_s, input int reading);
      send_request(KIND_AUDIO, 16'(left_s), 16'(right_s), 10'(reading),
                   6'($urandom), 16'($urandom));
   endtask

   task automatic send_coef(input int tap, input int value);
      send_request(KIND_COEF, 16'($urandom), 16'($urandom), 10'($urandom),
                   6'(tap), 16'(value));
   endtask

   task automatic write_register(input csr_index_type idx, input int value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = 10'(value);
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   task automatic set_levels(input int bypass_at, input int equalize_at);
      write_register(CSR_BYPASS_LEVEL, bypass_at);
      write_register(CSR_EQUALIZE_LEVEL, equalize_at);
      bypass_setting   = bypass_at;
      equalize_setting = equalize_at;
   endtask

   task automatic wait_quiet();
      req_valid = 1'b0;
      while (awaiting_count != 0) @(negedge clock);
      repeat (TAP_COUNT + 8) @(negedge clock);
   endtask

   task automatic send_random_item();
      int pick;
      int reading;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         send_coef($urandom_range(0, 63), random_coef());
      end else begin
         if (pick < 50) reading = bypass_setting;
         else if (pick < 88) reading = equalize_setting;
         else reading = $urandom_range(0, 1023);
         reading = reading + $urandom_range(0, 26) - 13;
         if (reading < 0) reading = 0;
         if (reading > 1023) reading = 1023;
         send_audio(random_sample(), random_sample(), reading);
      end
   endtask

   initial begin : rsp_backpressure
      int hold;
      hold      = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_ready = 1'b0;
            hold--;
         end else begin
            rsp_ready = 1'b1;
            hold = idle_span(rsp_stalls_on);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
            quiet = 0;
         else
            quiet++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_kind         = KIND_AUDIO;
      req_left_sample  = '0;
      req_right_sample = '0;
      req_button_level = '0;
      req_coef_index   = '0;
      req_coef_value   = '0;
      csr_we           = 1'b0;
      csr_index        = CSR_BYPASS_LEVEL;
      csr_wdata        = '0;
      req_gaps_on      = 1'b0;
      rsp_stalls_on    = 1'b0;
      bypass_setting   = 0;
      equalize_setting = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_levels(100, 300);
      send_audio(32767, -32768, 0);
      send_audio(-32768, 32767, 1023);
      send_coef(0, 32767);
      send_coef(1, 32767);
      send_coef(63, -32768);
      send_audio(32767, 32767, 300);
      send_audio(32767, -32768, 311);
      send_audio(-32768, -32768, 312);
      send_audio(-32768, -32768, 289);
      send_audio(0, 1, 288);
      send_audio(1, 0, 111);
      send_audio(-1, -1, 300);
      send_audio(5, -5, 88);
      send_audio(100, 200, 89);
      send_coef(63, 32767);
      send_coef(32, -1);
      wait_quiet();
      set_levels(5, 5);
      send_audio(1234, -1234, 0);
      send_audio(-777, 777, 16);
      send_audio(42, -42, 17);
      wait_quiet();
      set_levels(1023, 0);
      send_audio(300, -300, 0);
      send_audio(-300, 300, 11);
      send_audio(7, 8, 12);
      send_audio(9, 10, 1012);
      send_audio(11, 12, 1011);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_quiet();
         case (phase)
            0: set_levels(0, 1023);
            1: set_levels(1023, 0);
            2: begin
               bypass_setting = $urandom_range(0, 1023);
               set_levels(bypass_setting, bypass_setting);
            end
            3: begin
               bypass_setting = $urandom_range(0, 1023);
               set_levels(bypass_setting, (bypass_setting + $urandom_range(12, 24)) % 1024);
            end
            default: set_levels($urandom_range(0, 1023), $urandom_range(0, 1023));
         endcase
         req_gaps_on   = (phase != 0) && ($urandom_range(0, 3) != 0);
         rsp_stalls_on = (phase != 0) && ($urandom_range(0, 3) != 0);
         repeat (PHASE_ITEMS) send_random_item();
      end
      wait_quiet();

      if (mismatches == 0 && awaiting_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/sfeb_pkg.sv
hdl/sfeb_store.sv
hdl/sfeb_mac.sv
hdl/sfeb_seq.sv
hdl/stereo_fir_equalizer_bypass.sv
test/stereo_fir_equalizer_bypass_checker.sv
test/stereo_fir_equalizer_bypass_test.sv
